/* hdl/sda_pkg.sv */
// ----------------------------------------------------------------------------
// sda_pkg: shared types and constants for the sighting dedupe table
// Table geometry, command and status codes, and the entry record.
// ----------------------------------------------------------------------------
`default_nettype none
package sda_pkg;
  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdentBytes   = 32;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned CntW         = $clog2(TableEntries + 1);
  localparam int unsigned IdentW       = 8 * IdentBytes;
  localparam int unsigned LenW         = 6;

  localparam logic [1:0] CmdSight = 2'd0;
  localparam logic [1:0] CmdSweep = 2'd1;

  localparam logic [2:0] StNew     = 3'd0;
  localparam logic [2:0] StRefresh = 3'd1;
  localparam logic [2:0] StWeak    = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StSwept   = 3'd4;
  localparam logic [2:0] StCleared = 3'd5;

  localparam logic [0:0] RegRssi = 1'd0;
  localparam logic [0:0] RegAge  = 1'd1;

  typedef struct packed {
    logic [47:0]       addr;
    logic [IdentW-1:0] ident;
    logic [LenW-1:0]   len;
    logic [31:0]       seen;
    logic              kind;
    logic              phone;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);
endpackage
`default_nettype wire

/* hdl/sda_ram.sv */
// ----------------------------------------------------------------------------
// sda_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module sda_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

/* hdl/sighting_dedup_aging_table.sv */
// ----------------------------------------------------------------------------
// sighting_dedup_aging_table: radio sighting dedupe table with aging
// Top level: input normalization, entry walk sequencer and entry store.
// ----------------------------------------------------------------------------
// Sweeps, clears and sightings not filtered as weak walk the entry RAM one
// slot per cycle through its single port. A sweep or clear and a sighting
// that inserts or is dropped as full walk every slot, a refresh ends early at
// the matching slot, and a sighting filtered as weak skips the walk. Valid
// bits live in flip-flops and are cleared by reset at once; entry contents
// are in RAM and need no clearing. One command is in flight at a time; the
// next input beat is taken the cycle after the result beat.
`default_nettype none
module sighting_dedup_aging_table
  import sda_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [0:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [1:0]   command_i,
  input  wire logic [47:0]  source_addr_i,
  input  wire logic [5:0]   ident_len_i,
  input  wire logic [63:0]  ident_word_0_i,
  input  wire logic [63:0]  ident_word_1_i,
  input  wire logic [63:0]  ident_word_2_i,
  input  wire logic [63:0]  ident_word_3_i,
  input  wire logic         radio_kind_i,
  input  wire logic         phone_flag_i,
  input  wire logic signed [7:0] rssi_dbm_i,
  input  wire logic [31:0]  now_ms_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [2:0]        status_o,
  output logic [6:0]        evicted_count_o,
  output logic [6:0]        entry_count_o,
  output logic [6:0]        wifi_count_o,
  output logic [6:0]        ble_count_o,
  output logic [6:0]        phone_count_o
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_SCAN, S_INSERT, S_DONE} state_e;

  state_e                  state_q;
  logic signed [7:0]       thr_q;
  logic [31:0]             age_q;
  logic [TableEntries-1:0] valid_q;
  logic [CntW-1:0]         cnt_tot_q, cnt_wifi_q, cnt_ble_q, cnt_ph_q, evict_q;
  logic [IdxW:0]           idx_q;
  logic [IdxW-1:0]         free_q;
  logic                    free_ok_q;
  logic [1:0]              cmd_q;
  entry_t                  item_q, item_d;
  logic                    we;
  logic [IdxW-1:0]         ram_addr;
  entry_t                  wentry;
  logic [EntryW-1:0]       rdata;
  entry_t                  rentry;
  logic [IdxW-1:0]         cur;
  logic                    hit, old;
  logic [LenW-1:0]         len;
  logic [IdentW-1:0]       idv, mask;
  logic                    ld;

  always_comb begin
    idv = {ident_word_3_i, ident_word_2_i, ident_word_1_i, ident_word_0_i};
    len = (ident_len_i > LenW'(IdentBytes)) ? LenW'(IdentBytes) : ident_len_i;
    if (len >= LenW'(6) && idv[23:0] == 24'h07004C) begin
      len = LenW'(6);
    end
    for (int b = 0; b < IdentBytes; b++) begin
      mask[8*b +: 8] = {8{LenW'(b) < len}};
    end
    item_d.addr  = source_addr_i;
    item_d.ident = idv & mask;
    item_d.len   = len;
    item_d.seen  = now_ms_i;
    item_d.kind  = radio_kind_i;
    item_d.phone = phone_flag_i;
  end

  assign cur    = idx_q[IdxW-1:0];
  assign rentry = entry_t'(rdata);
  assign in_stall_o = (state_q != S_IDLE) || out_valid_o;
  assign ld     = in_valid_i && !in_stall_o;

  // scan reads slot idx while the previous slot's data is evaluated
  logic [IdxW-1:0] prev;
  logic            pvalid;
  assign prev   = cur - IdxW'(1);
  assign pvalid = valid_q[prev];
  assign hit = pvalid && ((item_q.len != '0)
             ? (rentry.len == item_q.len && rentry.ident == item_q.ident)
             : (rentry.len == '0 && rentry.addr == item_q.addr));
  assign old = pvalid && ((item_q.seen - rentry.seen) > age_q);

  always_comb begin
    we       = 1'b0;
    ram_addr = cur;
    wentry   = item_q;
    if (state_q == S_SCAN && cmd_q == CmdSight && hit) begin
      we       = 1'b1;
      ram_addr = prev;
      wentry   = rentry;
      wentry.seen = item_q.seen;
    end else if (state_q == S_INSERT) begin
      we       = free_ok_q;
      ram_addr = free_q;
    end
  end

  sda_ram #(.Width(EntryW), .Depth(TableEntries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (ram_addr),
    .wdata_i (EntryW'(wentry)),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      thr_q <= -8'sd80;
      age_q <= 32'd60000;
      valid_q <= '0;
      cnt_tot_q <= '0; cnt_wifi_q <= '0; cnt_ble_q <= '0; cnt_ph_q <= '0;
      evict_q <= '0;
      idx_q <= '0;
      free_q <= '0;
      free_ok_q <= 1'b0;
      cmd_q <= CmdSight;
      out_valid_o <= 1'b0;
      status_o <= StNew;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegRssi: thr_q <= cfg_data_i[7:0];
          RegAge:  age_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (ld) begin
            cmd_q <= command_i;
            evict_q <= '0;
            idx_q <= '0;
            free_ok_q <= 1'b0;
            if (command_i == CmdSight && rssi_dbm_i < thr_q) begin
              status_o <= StWeak;
              state_q <= S_DONE;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          idx_q <= idx_q + 1'b1;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (cmd_q == CmdSight) begin
            if (!pvalid && !free_ok_q) begin
              free_q <= prev;
              free_ok_q <= 1'b1;
            end
            if (hit) begin
              status_o <= StRefresh;
              state_q <= S_DONE;
            end else if (idx_q == (IdxW+1)'(TableEntries)) begin
              state_q <= S_INSERT;
            end
          end else begin
            if ((cmd_q == CmdSweep) ? old : pvalid) begin
              valid_q[prev] <= 1'b0;
              evict_q <= evict_q + 1'b1;
              cnt_tot_q <= cnt_tot_q - 1'b1;
              if (rentry.kind) cnt_ble_q <= cnt_ble_q - 1'b1;
              else cnt_wifi_q <= cnt_wifi_q - 1'b1;
              if (rentry.phone) cnt_ph_q <= cnt_ph_q - 1'b1;
            end
            if (idx_q == (IdxW+1)'(TableEntries)) begin
              status_o <= (cmd_q == CmdSweep) ? StSwept : StCleared;
              state_q <= S_DONE;
            end
          end
          if (idx_q != (IdxW+1)'(TableEntries)) idx_q <= idx_q + 1'b1;
        end
        S_INSERT: begin
          if (free_ok_q) begin
            valid_q[free_q] <= 1'b1;
            cnt_tot_q <= cnt_tot_q + 1'b1;
            if (item_q.kind) cnt_ble_q <= cnt_ble_q + 1'b1;
            else cnt_wifi_q <= cnt_wifi_q + 1'b1;
            if (item_q.phone) cnt_ph_q <= cnt_ph_q + 1'b1;
            status_o <= StNew;
          end else begin
            status_o <= StFull;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          out_valid_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) item_q <= item_d;
  end

  assign evicted_count_o = 7'(evict_q);
  assign entry_count_o   = 7'(cnt_tot_q);
  assign wifi_count_o    = 7'(cnt_wifi_q);
  assign ble_count_o     = 7'(cnt_ble_q);
  assign phone_count_o   = 7'(cnt_ph_q);
endmodule
`default_nettype wire

/* hdl/sda_checker.sv */
// ----------------------------------------------------------------------------
// sda_checker: port-level checks for the sighting dedupe table
// Result counts and handshake behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module sda_checker
  import sda_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [2:0] status_o,
  input wire logic [6:0] evicted_count_o,
  input wire logic [6:0] entry_count_o,
  input wire logic [6:0] wifi_count_o,
  input wire logic [6:0] ble_count_o
);
  a_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (wifi_count_o + ble_count_o) == entry_count_o)
    else $error("wifi plus ble differs from table size");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= 7'(TableEntries))
    else $error("table size above capacity");
  a_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StSwept && status_o != StCleared)
      |-> evicted_count_o == '0)
    else $error("eviction on a sighting");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(status_o))
    else $error("stalled result beat changed");
endmodule

bind sighting_dedup_aging_table sda_checker u_sda_checker (.*);
`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for sighting_dedup_aging_table
// Feeds sightings, sweeps and clears through the valid/stall channels with
// random gaps and stalls, keeps its own copy of the entry table and counts,
// and compares every result beat with the predicted one.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import sda_pkg::*;

  localparam logic [1:0] CmdClear    = 2'd2;
  localparam logic [1:0] CmdClearAlt = 2'd3;
  localparam int         Depth       = 64;
  localparam int         DrainWait   = 100;
  localparam int         LongHold    = 300;
  localparam int         StallLimit  = 3000;

  typedef struct {
    logic [1:0]         cmd;
    logic [47:0]        addr;
    logic [5:0]         len;
    logic [255:0]       ident;
    logic               kind;
    logic               phone;
    logic signed [7:0]  rssi;
    logic [31:0]        now;
  } sighting_t;

  typedef struct {
    logic [2:0] status;
    logic [6:0] evicted;
    logic [6:0] size;
    logic [6:0] wifi;
    logic [6:0] ble;
    logic [6:0] phones;
  } counts_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = RegRssi;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] command_i = CmdSight;
  logic [47:0] source_addr_i = '0;
  logic [5:0] ident_len_i = '0;
  logic [63:0] ident_word_0_i = '0, ident_word_1_i = '0;
  logic [63:0] ident_word_2_i = '0, ident_word_3_i = '0;
  logic radio_kind_i = 1'b0, phone_flag_i = 1'b0;
  logic signed [7:0] rssi_dbm_i = '0;
  logic [31:0] now_ms_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [6:0] evicted_count_o, entry_count_o, wifi_count_o, ble_count_o, phone_count_o;

  sighting_dedup_aging_table u_top (.*);

  always #10 clk_i = ~clk_i;

  // shadow table
  logic signed [7:0] thr_dbm;
  logic [31:0]       window_ms;
  logic              tab_valid [Depth];
  logic [47:0]       tab_addr  [Depth];
  logic [255:0]      tab_ident [Depth];
  logic [5:0]        tab_len   [Depth];
  logic [31:0]       tab_seen  [Depth];
  logic              tab_kind  [Depth];
  logic              tab_phone [Depth];
  int n_total, n_wifi, n_ble, n_phone;

  sighting_t pending_sightings[$];
  counts_t   expected_counts[$];
  int errors = 0;
  int n_sent = 0, n_recv = 0, n_new = 0, n_refresh = 0, n_full = 0, n_evicted = 0;
  bit quiet = 0;
  int hold_asked = 0, hold_done = 0, hold_left = 0, rx_wait = 0, tx_gap = 0;

  function automatic void queue_item(sighting_t s);
    pending_sightings.insert(pending_sightings.size(), s);
  endfunction

  function automatic int draw_wait();
    if (quiet) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
  endfunction

  function automatic void drop_slot(int i);
    tab_valid[i] = 1'b0;
    n_total--;
    if (tab_kind[i]) n_ble--; else n_wifi--;
    if (tab_phone[i]) n_phone--;
  endfunction

  function automatic counts_t update_table(sighting_t s);
    counts_t r;
    int len, slot;
    logic [255:0] mask, id;
    bit hit;
    r.evicted = '0;
    if (s.cmd == CmdSight) begin
      if (s.rssi < thr_dbm) begin
        r.status = StWeak;
      end else begin
        len = (s.len > IdentBytes) ? IdentBytes : s.len;
        if (len >= 6 && s.ident[7:0] == 8'h4C && s.ident[15:8] == 8'h00 &&
            s.ident[23:16] == 8'h07) len = 6;
        mask = (256'd1 << (8 * len)) - 256'd1;
        id = s.ident & mask;
        hit = 0;
        for (int i = 0; i < Depth && !hit; i++) begin
          if (tab_valid[i] && ((len != 0 && tab_len[i] == len && tab_ident[i] == id) ||
              (len == 0 && tab_len[i] == 0 && tab_addr[i] == s.addr))) begin
            tab_seen[i] = s.now;
            hit = 1;
          end
        end
        if (hit) begin
          r.status = StRefresh;
          n_refresh++;
        end else begin
          slot = -1;
          for (int i = Depth - 1; i >= 0; i--) if (!tab_valid[i]) slot = i;
          if (slot < 0) begin
            r.status = StFull;
            n_full++;
          end else begin
            tab_valid[slot] = 1'b1;
            tab_addr[slot] = s.addr;
            tab_ident[slot] = id;
            tab_len[slot] = 6'(len);
            tab_seen[slot] = s.now;
            tab_kind[slot] = s.kind;
            tab_phone[slot] = s.phone;
            n_total++;
            if (s.kind) n_ble++; else n_wifi++;
            if (s.phone) n_phone++;
            r.status = StNew;
            n_new++;
          end
        end
      end
    end else if (s.cmd == CmdSweep) begin
      for (int i = 0; i < Depth; i++)
        if (tab_valid[i] && 32'(s.now - tab_seen[i]) > window_ms) begin
          drop_slot(i);
          r.evicted++;
        end
      r.status = StSwept;
    end else begin
      for (int i = 0; i < Depth; i++)
        if (tab_valid[i]) begin
          drop_slot(i);
          r.evicted++;
        end
      r.status = StCleared;
    end
    n_evicted += r.evicted;
    r.size = 7'(n_total);
    r.wifi = 7'(n_wifi);
    r.ble = 7'(n_ble);
    r.phones = 7'(n_phone);
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at beat %0d: %s got %0d want %0d", n_recv, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drv
    sighting_t s;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        s.cmd = command_i; s.addr = source_addr_i; s.len = ident_len_i;
        s.ident = {ident_word_3_i, ident_word_2_i, ident_word_1_i, ident_word_0_i};
        s.kind = radio_kind_i; s.phone = phone_flag_i; s.rssi = rssi_dbm_i;
        s.now = now_ms_i;
        expected_counts.insert(expected_counts.size(), update_table(s));
        n_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_sightings.size() > 0) begin
          s = pending_sightings.pop_front();
          command_i <= s.cmd; source_addr_i <= s.addr; ident_len_i <= s.len;
          {ident_word_3_i, ident_word_2_i, ident_word_1_i, ident_word_0_i} <= s.ident;
          radio_kind_i <= s.kind; phone_flag_i <= s.phone; rssi_dbm_i <= s.rssi;
          now_ms_i <= s.now;
          in_valid_i <= 1'b1;
          tx_gap <= draw_wait();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : mon
    counts_t e;
    int w;
    logic nxt;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_counts.size() == 0) begin
          report("unexpected beat, status", 32'(status_o), 32'd0);
        end else begin
          e = expected_counts.pop_front();
          if (status_o !== e.status) report("status", 32'(status_o), 32'(e.status));
          if (evicted_count_o !== e.evicted)
            report("evicted_count", 32'(evicted_count_o), 32'(e.evicted));
          if (entry_count_o !== e.size)
            report("entry_count", 32'(entry_count_o), 32'(e.size));
          if (wifi_count_o !== e.wifi) report("wifi_count", 32'(wifi_count_o), 32'(e.wifi));
          if (ble_count_o !== e.ble) report("ble_count", 32'(ble_count_o), 32'(e.ble));
          if (phone_count_o !== e.phones)
            report("phone_count", 32'(phone_count_o), 32'(e.phones));
        end
        n_recv++;
      end
      nxt = 1'b0;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        nxt = 1'b1;
      end else if (hold_asked > hold_done) begin
        hold_done <= hold_done + 1;
        hold_left <= LongHold;
        nxt = 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        w = draw_wait();
        rx_wait <= w;
        nxt = (w != 0);
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        nxt = (rx_wait > 1);
      end
      out_stall_i <= nxt;
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("timeout: no beat for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  logic [47:0]  addr_pool  [16];
  logic [255:0] ident_pool [12];
  logic [5:0]   len_pool   [12];
  logic [31:0]  clock_ms = 32'd1000;

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [255:0] rnd256();
    return {rnd64(), rnd64(), rnd64(), rnd64()};
  endfunction

  function automatic sighting_t mk(logic [1:0] cmd, logic [47:0] addr, logic [5:0] len,
                                   logic [255:0] ident, logic kind, logic phone,
                                   logic signed [7:0] rssi, logic [31:0] now);
    sighting_t s;
    s.cmd = cmd; s.addr = addr; s.len = len; s.ident = ident;
    s.kind = kind; s.phone = phone; s.rssi = rssi; s.now = now;
    return s;
  endfunction

  function automatic sighting_t random_sighting();
    sighting_t s;
    int pick, k;
    pick = $urandom_range(0, 99);
    clock_ms = clock_ms + $urandom_range(0, 3000);
    if ($urandom_range(0, 199) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
    s = mk(CmdSight, ($urandom_range(0, 1) ? addr_pool[$urandom_range(0, 15)]
                                            : 48'(rnd64())), 6'd0, rnd256(),
           1'($urandom), 1'($urandom),
           ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(-$urandom_range(0, 60)),
           clock_ms);
    if (pick < 8) s.cmd = CmdSweep;
    else if (pick < 11) s.cmd = CmdClear;
    else if (pick < 13) s.cmd = CmdClearAlt;
    else begin
      pick = $urandom_range(0, 9);
      if (pick < 3) s.len = 0;
      else if (pick < 6) begin
        k = $urandom_range(0, 11);
        s.len = len_pool[k];
        s.ident = ident_pool[k] | (rnd256() & ~((256'd1 << (8 * len_pool[k])) - 256'd1));
      end else if (pick < 7) begin
        s.len = 6'($urandom_range(6, 63));
        s.ident[23:0] = 24'h07004C;
      end else s.len = 6'($urandom);
    end
    return s;
  endfunction

  task automatic drain();
    while (!(pending_sightings.size() == 0 && !in_valid_i && expected_counts.size() == 0))
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_config(logic signed [7:0] thr, logic [31:0] win);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= RegRssi; cfg_data_i <= 32'(thr);
    @(posedge clk_i);
    cfg_index_i <= RegAge; cfg_data_i <= win;
    thr_dbm = thr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    window_ms = win;
  endtask

  task automatic random_phase(logic signed [7:0] thr, logic [31:0] win, int n, bit hold);
    set_config(thr, win);
    for (int i = 0; i < n; i++) queue_item(random_sighting());
    if (hold) hold_asked++;
    drain();
  endtask

  initial begin
    logic [255:0] id6;
    thr_dbm = -8'sd80;
    window_ms = 32'd60000;
    for (int i = 0; i < Depth; i++) tab_valid[i] = 1'b0;
    n_total = 0; n_wifi = 0; n_ble = 0; n_phone = 0;
    for (int i = 0; i < 16; i++) addr_pool[i] = 48'(rnd64());
    for (int i = 0; i < 12; i++) begin
      len_pool[i] = 6'($urandom_range(1, 32));
      ident_pool[i] = rnd256() & ((256'd1 << (8 * len_pool[i])) - 256'd1);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    id6 = rnd256();
    id6[23:0] = 24'h07004C;
    queue_item(mk(CmdSight, 48'h0, 6'd0, '0, 1'b0, 1'b0, -8'sd80, 32'd0));
    queue_item(mk(CmdSight, 48'hFFFF_FFFF_FFFF, 6'd0, '0, 1'b1, 1'b1,
                  -8'sd81, 32'd5));
    queue_item(mk(CmdSight, 48'h0, 6'd0, '1, 1'b1, 1'b0, 8'sd127, 32'd9));
    queue_item(mk(CmdSight, 48'h1, 6'd0, '0, 1'b0, 1'b1, -8'sd128, 32'd9));
    queue_item(mk(CmdSight, 48'hFFFF_FFFF_FFFF, 6'd0, '1, 1'b1, 1'b1,
                  8'sd0, 32'hFFFF_FFF0));
    queue_item(mk(CmdSight, 48'h5, 6'd32, id6, 1'b1, 1'b1, -8'sd10, 32'd20));
    queue_item(mk(CmdSight, 48'h6, 6'd6, id6 & 256'hFFFF_FFFF_FFFF,
                  1'b0, 1'b0, -8'sd10, 32'd21));
    queue_item(mk(CmdSight, 48'h7, 6'd63, '1, 1'b0, 1'b1, -8'sd1, 32'd22));
    queue_item(mk(CmdSight, 48'h8, 6'd32, '1, 1'b1, 1'b0, -8'sd1, 32'd23));
    queue_item(mk(CmdSight, 48'h9, 6'd5, {232'h0, 24'h07004C}, 1'b1, 1'b0,
                  -8'sd1, 32'd24));
    queue_item(mk(CmdSight, 48'h9, 6'd5, {rnd64(), 192'h07004C}, 1'b0, 1'b0,
                  -8'sd1, 32'd25));
    queue_item(mk(CmdSight, 48'hA, 6'd1, '0, 1'b0, 1'b1, -8'sd5, 32'd26));
    queue_item(mk(CmdSweep, '0, '0, '0, 1'b0, 1'b0, '0, 32'd30));
    queue_item(mk(CmdSweep, '0, '0, '0, 1'b0, 1'b0, '0, 32'd70000));
    queue_item(mk(CmdSight, 48'hB, 6'd0, '0, 1'b0, 1'b0, -8'sd5,
                  32'hFFFF_FFFE));
    queue_item(mk(CmdSweep, '0, '0, '0, 1'b0, 1'b0, '0, 32'd100));
    queue_item(mk(CmdClear, '1, '1, '1, 1'b1, 1'b1, '1, '1));
    queue_item(mk(CmdSight, 48'hC, 6'd0, '0, 1'b1, 1'b1, -8'sd5, 32'd200));
    queue_item(mk(CmdClearAlt, '0, '0, '0, 1'b0, 1'b0, '0, '0));
    drain();

    random_phase(-8'sd128, 32'd0, 300, 0);
    random_phase(8'sd0, 32'hFFFF_FFFF, 300, 1);
    random_phase(-8'sd60, 32'd20000, 300, 0);
    quiet = 1;
    random_phase(-8'sd80, 32'd60000, 300, 0);
    quiet = 0;
    random_phase(-8'sd128, 32'd5000, 300, 1);
    random_phase(-8'sd40, 32'd90000, 300, 0);

    $display("covered %0d commands, %0d results: %0d new, %0d refreshed, %0d full drops",
             n_sent, n_recv, n_new, n_refresh, n_full);
    $display("entries evicted by sweeps and clears: %0d", n_evicted);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
